[rtl/core/pkbd_pkg.sv]
// Shared types, constants and helper functions for the per-key burst detector.
package pkbd_pkg;

   // Field widths
   localparam int KEY_W      = 12;
   localparam int IDX_W      = 11;
   localparam int TIME_W     = 64;
   localparam int WINDOW_W   = 32;
   localparam int COUNT_W    = 16;
   localparam int PENALTY_W  = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Table geometry default
   localparam int TABLE_SIZE_DEFAULT = 512;

   // Register reset values and limits
   localparam logic [WINDOW_W-1:0]  WINDOW_RESET = WINDOW_W'(1000000);
   localparam logic [COUNT_W-1:0]   THRESH_RESET = COUNT_W'(10);
   localparam logic [COUNT_W-1:0]   COUNT_MAX    = {COUNT_W{1'b1}};
   localparam logic [PENALTY_W-1:0] PENALTY_BASE = PENALTY_W'(10);

   // Register select (byte address bit 2)
   localparam logic REG_WINDOW = 1'b0;
   localparam logic REG_THRESH = 1'b1;

   // One classified item waiting in the queue
   typedef struct packed {
      logic                 key_valid;
      logic [IDX_W-1:0]     index;
      logic [PENALTY_W-1:0] penalty;
      logic [TIME_W-1:0]    timestamp;
   } pkbd_entry_type;

   // Queue fill status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } pkbd_queue_status_type;

   // Back end sequencer
   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC
   } pkbd_back_state_type;

   // 10 + (idx mod 10); quotient by reciprocal multiply, exact for idx < 2048
   function automatic logic [PENALTY_W-1:0] penalty_of(input logic [IDX_W-1:0] idx);
      logic [25:0]      prod;
      logic [IDX_W-1:0] quot;
      logic [IDX_W-1:0] rem;
      prod = 26'(idx) * 26'd3277;
      quot = prod[25:15];
      rem  = idx - ((quot << 3) + (quot << 1));
      if (rem >= IDX_W'(10)) begin
         rem = rem - IDX_W'(10);
      end
      return PENALTY_BASE + PENALTY_W'(rem[3:0]);
   endfunction

endpackage

[rtl/core/pkbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pkbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/pkbd_queue.sv]
// Two-entry queue between the classifying front end and the table back end.
module pkbd_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  pkbd_pkg::pkbd_entry_type       push_entry,
   input  logic                           pop,
   output pkbd_pkg::pkbd_entry_type       head,
   output pkbd_pkg::pkbd_queue_status_type status
);

   pkbd_pkg::pkbd_entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

endmodule

[rtl/core/pkbd_front.sv]
// Front end: takes items, checks the key range and precomputes the penalty.
module pkbd_front #(
   parameter int TABLE_SIZE = pkbd_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [pkbd_pkg::KEY_W-1:0]     req_event_key,
   input  logic        [pkbd_pkg::TIME_W-1:0]    req_timestamp_ns,
   input  logic                                  clearing,
   input  pkbd_pkg::pkbd_queue_status_type       q_status,
   output logic                                  push,
   output pkbd_pkg::pkbd_entry_type              push_entry
);

   logic [pkbd_pkg::IDX_W-1:0] idx;
   logic                       in_range;

   // Hold off while the table is being cleared or the queue is full
   assign req_stall = clearing | q_status.full;
   assign push      = req_valid & ~req_stall;

   // Negative keys and keys past the table end are passed on as ignored
   assign idx      = req_event_key[pkbd_pkg::IDX_W-1:0];
   assign in_range = ~req_event_key[pkbd_pkg::KEY_W-1] &&
                     ({1'b0, idx} < pkbd_pkg::KEY_W'(TABLE_SIZE));

   always_comb begin
      push_entry.key_valid = in_range;
      push_entry.index     = idx;
      push_entry.penalty   = pkbd_pkg::penalty_of(idx);
      push_entry.timestamp = req_timestamp_ns;
   end

endmodule

[rtl/core/pkbd_back.sv]
// Back end: clears the table, then does one read-modify-write per in-range item.
module pkbd_back #(
   parameter int TABLE_SIZE = pkbd_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pkbd_pkg::pkbd_queue_status_type     q_status,
   input  pkbd_pkg::pkbd_entry_type            head,
   output logic                                pop,
   input  logic [pkbd_pkg::WINDOW_W-1:0]       window_ns,
   input  logic [pkbd_pkg::COUNT_W-1:0]        burst_threshold,
   output logic                                clearing,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_key_valid,
   output logic [pkbd_pkg::COUNT_W-1:0]        rsp_burst_count,
   output logic                                rsp_suspicious,
   output logic [pkbd_pkg::PENALTY_W-1:0]      rsp_penalty_us
);

   localparam int AW     = $clog2(TABLE_SIZE);
   localparam int WORD_W = pkbd_pkg::COUNT_W + pkbd_pkg::TIME_W;

   pkbd_pkg::pkbd_back_state_type state_ff, state_in;
   logic [AW-1:0]                 clr_cnt_ff, clr_cnt_in;
   pkbd_pkg::pkbd_entry_type      work_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_key_valid_ff;
   logic [pkbd_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic                          rsp_sus_ff;
   logic [pkbd_pkg::PENALTY_W-1:0] rsp_penalty_ff;

   logic                          ram_wr_en, ram_rd_en;
   logic [AW-1:0]                 ram_wr_addr, ram_rd_addr;
   logic [WORD_W-1:0]             ram_wr_data, ram_rd_data;

   logic                          out_free, load_out, clr_last;
   logic [pkbd_pkg::TIME_W-1:0]   prev_ts, gap;
   logic [pkbd_pkg::COUNT_W-1:0]  old_count, new_count;
   logic                          in_window, is_sus;

   pkbd_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign clr_last = (clr_cnt_ff == AW'(TABLE_SIZE - 1));

   // Count update from the entry just read
   always_comb begin
      old_count = ram_rd_data[WORD_W-1:pkbd_pkg::TIME_W];
      prev_ts   = ram_rd_data[pkbd_pkg::TIME_W-1:0];
      gap       = work_ff.timestamp - prev_ts;
      in_window = gap < {{(pkbd_pkg::TIME_W-pkbd_pkg::WINDOW_W){1'b0}}, window_ns};
      if (!in_window) begin
         new_count = pkbd_pkg::COUNT_W'(1);
      end else if (old_count == pkbd_pkg::COUNT_MAX) begin
         new_count = old_count;
      end else begin
         new_count = old_count + pkbd_pkg::COUNT_W'(1);
      end
      is_sus = work_ff.key_valid && (new_count > burst_threshold);
   end

   // Next state
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         pkbd_pkg::BK_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_last) begin
               state_in = pkbd_pkg::BK_IDLE;
            end
         end
         pkbd_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               state_in = pkbd_pkg::BK_EXEC;
            end
         end
         pkbd_pkg::BK_EXEC: begin
            if (out_free) begin
               state_in = pkbd_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = pkbd_pkg::BK_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      pop         = 1'b0;
      load_out    = 1'b0;
      clearing    = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = head.index[AW-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = work_ff.index[AW-1:0];
      ram_wr_data = {new_count, work_ff.timestamp};
      case (state_ff)
         pkbd_pkg::BK_CLEAR: begin
            clearing    = 1'b1;
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = '0;
         end
         pkbd_pkg::BK_IDLE: begin
            pop       = ~q_status.empty;
            ram_rd_en = ~q_status.empty;
         end
         pkbd_pkg::BK_EXEC: begin
            load_out  = out_free;
            ram_wr_en = out_free & work_ff.key_valid;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = load_out | (rsp_valid_ff & rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pkbd_pkg::BK_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         work_ff <= head;
      end
      if (load_out) begin
         rsp_key_valid_ff <= work_ff.key_valid;
         rsp_count_ff     <= work_ff.key_valid ? new_count : '0;
         rsp_sus_ff       <= is_sus;
         rsp_penalty_ff   <= is_sus ? work_ff.penalty : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_key_valid   = rsp_key_valid_ff;
   assign rsp_burst_count = rsp_count_ff;
   assign rsp_suspicious  = rsp_sus_ff;
   assign rsp_penalty_us  = rsp_penalty_ff;

endmodule

[rtl/core/per_key_burst_detector_unit.sv]
// Top level of the per-key burst detector: register port, front, queue, back.
//
// Usage:
//  - Input channel req_*: one item per accepted handshake (req_valid high,
//    req_stall low) carries a signed key and a 64-bit nanosecond timestamp.
//  - Result channel rsp_*: exactly one item per input item, in order, held in
//    an output register until the receiver drops rsp_stall.
//  - Registers window_ns (byte address 0) and burst_threshold (address 4) are
//    written and read over the APB-style port; write them only while idle.
//  - Flow: an accepted item passes the queue slot, the table read register and
//    the output register; the back end takes one item at a time, a table read
//    followed by the update and write-back, before it pops the next.
//  - A two-entry queue lets the front take items while the back end or the
//    receiver is stalled; req_stall rises only when that queue is full or the table is being cleared.
//  - Reset: a clearing pass zeroes the table, one entry per cycle, in address
//    order; req_stall stays high during it. Registers return to their reset
//    values at once.
//  - While rsp_stall is high the finished item holds, one more item waits in
//    the back end and the queue fills before req_stall rises.
module per_key_burst_detector_unit #(
   parameter int TABLE_SIZE = pkbd_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [pkbd_pkg::KEY_W-1:0]    req_event_key,
   input  logic        [pkbd_pkg::TIME_W-1:0]   req_timestamp_ns,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_key_valid,
   output logic [pkbd_pkg::COUNT_W-1:0]         rsp_burst_count,
   output logic                                 rsp_suspicious,
   output logic [pkbd_pkg::PENALTY_W-1:0]       rsp_penalty_us,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [pkbd_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [pkbd_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [pkbd_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   logic [pkbd_pkg::WINDOW_W-1:0] window_ff, window_in;
   logic [pkbd_pkg::COUNT_W-1:0]  thresh_ff, thresh_in;
   logic                          csr_write;

   pkbd_pkg::pkbd_entry_type        push_entry, head;
   pkbd_pkg::pkbd_queue_status_type q_status;
   logic                            push, pop, clearing;

   // Register port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      window_in = window_ff;
      thresh_in = thresh_ff;
      if (csr_write) begin
         case (paddr[2])
            pkbd_pkg::REG_WINDOW: window_in = pwdata[pkbd_pkg::WINDOW_W-1:0];
            pkbd_pkg::REG_THRESH: thresh_in = pwdata[pkbd_pkg::COUNT_W-1:0];
            default: window_in = window_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= pkbd_pkg::WINDOW_RESET;
         thresh_ff <= pkbd_pkg::THRESH_RESET;
      end else begin
         window_ff <= window_in;
         thresh_ff <= thresh_in;
      end
   end

   always_comb begin
      case (paddr[2])
         pkbd_pkg::REG_WINDOW: prdata = window_ff;
         pkbd_pkg::REG_THRESH: prdata = pkbd_pkg::CSR_DATA_W'(thresh_ff);
         default:              prdata = '0;
      endcase
   end

   pkbd_front #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_event_key    (req_event_key),
      .req_timestamp_ns (req_timestamp_ns),
      .clearing         (clearing),
      .q_status         (q_status),
      .push             (push),
      .push_entry       (push_entry)
   );

   pkbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   pkbd_back #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .head            (head),
      .pop             (pop),
      .window_ns       (window_ff),
      .burst_threshold (thresh_ff),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_valid   (rsp_key_valid),
      .rsp_burst_count (rsp_burst_count),
      .rsp_suspicious  (rsp_suspicious),
      .rsp_penalty_us  (rsp_penalty_us)
   );

   // No result can be pending while the table is still being cleared
   assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid && q_status.empty)
      else $error("result or queued item during table clear");

   // An ignored key yields an all-zero result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_key_valid |->
         rsp_burst_count == '0 && !rsp_suspicious && rsp_penalty_us == '0)
      else $error("ignored key produced a nonzero result");

   // A processed key always has a count of at least one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_valid |-> rsp_burst_count != '0)
      else $error("processed key with zero burst count");

   // A flagged item lies above the threshold and carries a penalty of 10..19
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_suspicious |->
         rsp_burst_count > thresh_ff && rsp_penalty_us >= pkbd_pkg::PENALTY_BASE &&
         rsp_penalty_us < pkbd_pkg::PENALTY_W'(20))
      else $error("suspicious result with bad count or penalty");

endmodule

[tb/tb.sv]
// Self-checking testbench for the per-key burst detector unit.
`timescale 1ns / 1ps

module tb;
   import pkbd_pkg::*;

   localparam int KEYS = TABLE_SIZE_DEFAULT;
   localparam logic [CSR_ADDR_W-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_THRESH = {REG_THRESH, 2'b00};
   localparam int DRAIN_CYCLES = 8;

   // Expected fields of one result item
   typedef struct packed {
      logic                 key_valid;
      logic [COUNT_W-1:0]   count;
      logic                 suspicious;
      logic [PENALTY_W-1:0] penalty;
   } burst_verdict_type;

   // Scoreboard: own copy of the per-key table and registers
   class burst_scoreboard_type;
      logic [TIME_W-1:0]   last_ns [KEYS];
      logic [COUNT_W-1:0]  hits [KEYS];
      logic [WINDOW_W-1:0] window;
      logic [COUNT_W-1:0]  threshold;
      burst_verdict_type   due_q[$];
      int errors;
      int checked;
      int flagged;
      int ignored;

      function new();
         foreach (last_ns[i]) begin
            last_ns[i] = '0;
            hits[i]    = '0;
         end
         window    = WINDOW_RESET;
         threshold = THRESH_RESET;
         errors    = 0;
         checked   = 0;
         flagged   = 0;
         ignored   = 0;
      endfunction

      // Update the table for an accepted item and queue its expected result
      function void note_event(logic signed [KEY_W-1:0] key, logic [TIME_W-1:0] ts);
         burst_verdict_type  v;
         int                 idx;
         logic [COUNT_W-1:0] c;
         v = '0;
         if (key >= 0 && key < KEYS) begin
            idx = int'(key);
            c   = hits[idx];
            // wrapped gap, strictly below the window continues the burst
            if (ts - last_ns[idx] < TIME_W'(window)) begin
               if (c != COUNT_MAX) c = c + 1'b1;
            end else begin
               c = COUNT_W'(1);
            end
            hits[idx]    = c;
            last_ns[idx] = ts;
            v.key_valid  = 1'b1;
            v.count      = c;
            v.suspicious = (c > threshold);
            if (v.suspicious) v.penalty = PENALTY_BASE + PENALTY_W'(idx % 10);
         end
         due_q.push_back(v);
      endfunction

      function void cmp(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      // Compare one accepted result with the oldest expectation
      function void check_result(burst_verdict_type got);
         burst_verdict_type want;
         if (due_q.size() == 0) begin
            $display("%0t: result with nothing expected: expected none, got %0h",
                     $time, got);
            errors++;
            return;
         end
         want = due_q.pop_front();
         checked++;
         if (!want.key_valid) ignored++;
         if (want.suspicious) flagged++;
         cmp("key_valid", want.key_valid, got.key_valid);
         cmp("burst_count", want.count, got.count);
         cmp("suspicious", want.suspicious, got.suspicious);
         cmp("penalty_us", want.penalty, got.penalty);
      endfunction
   endclass

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   // Block ports
   logic                           req_valid        = 1'b0;
   logic                           req_stall;
   logic signed [KEY_W-1:0]        req_event_key    = '0;
   logic        [TIME_W-1:0]       req_timestamp_ns = '0;
   logic                           rsp_valid;
   logic                           rsp_stall        = 1'b0;
   logic                           rsp_key_valid;
   logic [COUNT_W-1:0]             rsp_burst_count;
   logic                           rsp_suspicious;
   logic [PENALTY_W-1:0]           rsp_penalty_us;
   logic                           psel             = 1'b0;
   logic                           penable          = 1'b0;
   logic                           pwrite           = 1'b0;
   logic [CSR_ADDR_W-1:0]          paddr            = '0;
   logic [CSR_DATA_W-1:0]          pwdata           = '0;
   logic [CSR_DATA_W-1:0]          prdata;
   logic                           pready;

   burst_scoreboard_type    board;
   burst_verdict_type       seen;
   bit                      no_gaps  = 1'b0;
   logic [TIME_W-1:0]       clock_ns = '0;
   logic signed [KEY_W-1:0] last_key = '0;

   per_key_burst_detector_unit #(
      .TABLE_SIZE(KEYS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_event_key    (req_event_key),
      .req_timestamp_ns (req_timestamp_ns),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_valid    (rsp_key_valid),
      .rsp_burst_count  (rsp_burst_count),
      .rsp_suspicious   (rsp_suspicious),
      .rsp_penalty_us   (rsp_penalty_us),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // Random idling, with a 13 percent chance per call unless a quiet stretch is on
   function automatic bit take_gap();
      return !no_gaps && ($urandom_range(99) < 13);
   endfunction

   // Result side: check accepted items, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         seen = {rsp_key_valid, rsp_burst_count, rsp_suspicious, rsp_penalty_us};
         board.check_result(seen);
      end
      rsp_stall <= take_gap();
   end

   // Offer one item and hold it until accepted
   task automatic send_event(input logic signed [KEY_W-1:0] key,
                             input logic [TIME_W-1:0] ts);
      while (take_gap()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_event_key    <= key;
      req_timestamp_ns <= ts;
      do @(posedge clock); while (req_stall);
      board.note_event(key, ts);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr,
                           output logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data     = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Stop offering items, wait for every result, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      while (board.due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers while idle and read them back
   task automatic program_regs(input logic [WINDOW_W-1:0] win,
                               input logic [COUNT_W-1:0] thr);
      logic [CSR_DATA_W-1:0] rd;
      settle();
      csr_write(ADDR_WINDOW, win);
      board.window = win;
      // upper bits are junk; only the low 16 bits hold the threshold
      csr_write(ADDR_THRESH, {16'($urandom), thr});
      board.threshold = thr;
      csr_read(ADDR_WINDOW, rd);
      board.cmp("window_ns readback", win, rd);
      csr_read(ADDR_THRESH, rd);
      board.cmp("burst_threshold readback", thr, rd[COUNT_W-1:0]);
   endtask

   // Mostly bursty traffic on a few hot keys, some spread keys and noise
   task automatic random_phase(input int n);
      logic signed [KEY_W-1:0] key;
      logic [WINDOW_W-1:0]     w;
      int unsigned             kpick;
      int unsigned             tpick;
      w = board.window;
      for (int i = 0; i < n; i++) begin
         kpick = $urandom_range(99);
         tpick = $urandom_range(99);
         if (kpick < 15) key = last_key;
         else if (kpick < 25) key = KEY_W'($urandom);
         else if (kpick < 70) key = KEY_W'($urandom_range(7));
         else key = KEY_W'($urandom_range(KEYS - 1));
         if (tpick < 3) begin
            clock_ns = {$urandom, $urandom};
         end else if (tpick < 5) begin
            // just below the wrap point
            clock_ns = {32'hFFFF_FFFF, $urandom};
         end else if (kpick < 15 && tpick < 40) begin
            // repeat of the same key with a gap right at the window edge
            clock_ns = clock_ns + TIME_W'(w) + TIME_W'($urandom_range(2)) - 1;
         end else begin
            clock_ns = clock_ns + TIME_W'($urandom_range(w >> 5));
         end
         send_event(key, clock_ns);
         last_key = key;
      end
   endtask

   // Main sequence
   initial begin
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Keys out of range leave the table alone
      send_event(-12'sd2048, 64'hFFFF_FFFF_FFFF_FFFF);
      send_event(-12'sd1, 64'd0);
      send_event(12'sd512, 64'd5);
      send_event(12'sd2047, {$urandom, $urandom});
      // Never-seen key compares its timestamp itself; gap equal to window restarts
      send_event(12'sd0, 64'd999_999);
      send_event(12'sd0, 64'd1_999_999);
      send_event(12'sd0, 64'd2_999_997);
      send_event(12'sd511, 64'd1_000_000);
      // Difference across the 64-bit wrap
      send_event(12'sd1, 64'hFFFF_FFFF_FFFF_FFF0);
      send_event(12'sd1, 64'd5);
      // Short burst that crosses the reset threshold
      for (int i = 0; i < 12; i++) send_event(12'sd9, 64'd100 + i);

      // Random traffic under several register settings
      program_regs(WINDOW_RESET, THRESH_RESET);
      random_phase(270);
      program_regs('0, '0);
      random_phase(260);
      program_regs('1, '1);
      random_phase(260);
      program_regs('1, '0);
      no_gaps = 1'b1;
      random_phase(260);
      no_gaps = 1'b0;
      program_regs(WINDOW_W'(1000), COUNT_W'(3));
      random_phase(270);
      program_regs(WINDOW_W'(64), COUNT_W'(1));
      random_phase(270);
      program_regs(WINDOW_W'($urandom_range(100000, 1)), COUNT_W'($urandom_range(20)));
      random_phase(260);

      settle();
      $display("Checked %0d results: %0d out-of-range keys, %0d flagged suspicious,",
               board.checked, board.ignored, board.flagged);
      $display("after directed edge cases and random traffic under 7 register settings.");
      if (board.errors == 0 && board.due_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
